### rtl/glac_pkg.sv
// Package for the genotype likelihood accumulator: sizes, item and queue types,
// quality tables and the genotype update map. No dependencies.
`default_nettype none
package glac_pkg;

    localparam int NUM_SAMPLES = 64;
    localparam int MAX_QUALITY = 63;
    localparam int NUM_CLASSES = 3;
    localparam int NUM_GENO    = 6;
    localparam int ROWS        = NUM_SAMPLES * NUM_CLASSES;
    localparam int ROW_W       = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int QIDX_W      = $clog2(MAX_QUALITY + 1);
    localparam int MATCH_SIZE  = 36;

    localparam logic signed [31:0] HALF_TERM   = -32'sd1233;
    localparam logic signed [31:0] INDEL_MATCH = -32'sd18;
    localparam logic signed [31:0] INDEL_ERROR = -32'sd8192;
    localparam logic [4:0]         SOLID_CAP   = 5'd30;

    // request codes
    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_BASE  = 2'd1;
    localparam logic [1:0] REQ_INDEL = 2'd2;
    localparam logic [1:0] REQ_READ  = 2'd3;

    localparam logic [1:0] CLASS_COMBINED = 2'd3;

    // register indexes
    localparam logic [2:0] REG_FIRST  = 3'd0;
    localparam logic [2:0] REG_SECOND = 3'd1;
    localparam logic [2:0] REG_THIRD  = 3'd2;
    localparam logic [2:0] REG_SOLID  = 3'd3;
    localparam logic [2:0] REG_OFFSET = 3'd4;

    typedef struct packed {
        logic [2:0] first_allele;
        logic [2:0] second_allele;
        logic [2:0] third_allele;
        logic       solid_mode;
        logic [6:0] quality_offset;
    } cfg_t;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_UPDATE,
        OP_READ
    } op_t;

    typedef enum logic [1:0] {
        TERM_M,
        TERM_H,
        TERM_E
    } term_t;

    typedef struct packed {
        op_t                op;
        logic [ROW_W-1:0]   row;
        logic [1:0]         which;
        logic signed [31:0] m;
        logic signed [31:0] h;
        logic signed [31:0] e;
        logic               combined;
        logic               zero;
    } entry_t;

    typedef logic [NUM_GENO-1:0][31:0] row_t;

    typedef logic signed [31:0] err_tab_t [MAX_QUALITY+1];
    typedef logic signed [31:0] match_tab_t [MATCH_SIZE];

    localparam match_tab_t MATCH_TABLE = '{
        0, -2813, -1773, -1237, -903, -676, -515, -396, -307, -239,
        -187, -147, -116, -91, -72, -57, -45, -36, -28, -23,
        -18, -14, -11, -9, -7, -6, -4, -4, -3, -2,
        -2, -1, -1, -1, -1, -1
    };

    // error term -round(q * 4096 / 10), built at elaboration
    function automatic err_tab_t build_err();
        err_tab_t t;
        for (int i = 0; i <= MAX_QUALITY; i++) begin
            t[i] = -32'((i * 4096 + 5) / 10);
        end
        return t;
    endfunction

    localparam err_tab_t ERR_TABLE = build_err();

    // which term genotype j takes when allele w (0 A, 1 B, 2 C) is seen
    function automatic term_t term_sel(input logic [1:0] w, input int j);
        term_t t;
        t = TERM_E;
        unique case (w)
            2'd0:    if (j == 0) t = TERM_M; else if (j == 1 || j == 3) t = TERM_H;
            2'd1:    if (j == 2) t = TERM_M; else if (j == 1 || j == 4) t = TERM_H;
            default: if (j == 5) t = TERM_M; else if (j == 3 || j == 4) t = TERM_H;
        endcase
        return t;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [33:0] v);
        logic [31:0] r;
        if (v > 34'sd2147483647) r = 32'h7fff_ffff;
        else if (v < -34'sd2147483648) r = 32'h8000_0000;
        else r = v[31:0];
        return r;
    endfunction

endpackage
`default_nettype wire

### rtl/glac_ifs.sv
// Valid/ready channel interfaces for observation items and likelihood results.
// Depends on glac_pkg.
`default_nettype none
interface glac_obs_if
    import glac_pkg::*;
(
    input wire logic clk
);
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [5:0]  sample;
    logic [2:0]  base_allele;
    logic [7:0]  base_quality;
    logic [7:0]  mapping_quality;
    logic [1:0]  strand_class;
    logic        indel_slot;
    logic [15:0] indel_count;

    modport source (input clk, output valid, req_type, sample, base_allele, base_quality,
                    mapping_quality, strand_class, indel_slot, indel_count, input ready);
    modport sink (input clk, input valid, req_type, sample, base_allele, base_quality,
                  mapping_quality, strand_class, indel_slot, indel_count, output ready);
endinterface

interface glac_res_if
    import glac_pkg::*;
(
    input wire logic clk
);
    logic               valid;
    logic               ready;
    logic signed [31:0] ll_aa;
    logic signed [31:0] ll_ab;
    logic signed [31:0] ll_bb;
    logic signed [31:0] ll_ac;
    logic signed [31:0] ll_bc;
    logic signed [31:0] ll_cc;

    modport source (input clk, output valid, ll_aa, ll_ab, ll_bb, ll_ac, ll_bc, ll_cc,
                    input ready);
    modport sink (input clk, input valid, ll_aa, ll_ab, ll_bb, ll_ac, ll_bc, ll_cc,
                  output ready);
endinterface
`default_nettype wire

### rtl/genotype_likelihood_accumulator.sv
// Top level of the genotype likelihood accumulator: APB register file, front end,
// work queue and back end. Depends on glac_pkg, glac_ifs, glac_front, glac_fifo, glac_back.
//
// Usage:
//  - obs (valid/ready sink) carries items: clear, base observation, indel count, read out.
//  - result (valid/ready source) carries one item of six Q12 log10 likelihoods per read out.
//  - APB port holds the allele, SOLiD and quality offset registers at 4*index.
// Timing:
//  - The front end classifies an item in its accept cycle and queues it (two entries);
//    updates that change nothing are dropped there.
//  - The back end is one item at a time against a single-port row memory:
//    clear, update (read, then saturating write), single-class read out to the
//    result register, combined read out (one memory read per class).
// Reset: registers go to their reset values and every row's valid bit is
//  cleared at once, so the store reads as zero; no clearing pass is needed.
// Stall: the result register holds its item until taken; the back end then
//  waits, the queue fills, and obs.ready drops. Nothing is lost.
`default_nettype none
module genotype_likelihood_accumulator
    import glac_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    glac_obs_if.sink         obs,
    glac_res_if.source       result,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    cfg_t   cfg_reg;
    logic   q_push, q_pop, q_full, q_empty;
    entry_t q_data, q_head;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];

    // register writes complete in the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first_allele   <= 3'd0;
            cfg_reg.second_allele  <= 3'd1;
            cfg_reg.third_allele   <= 3'd2;
            cfg_reg.solid_mode     <= 1'b0;
            cfg_reg.quality_offset <= 7'd33;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_idx)
                REG_FIRST:  cfg_reg.first_allele   <= pwdata[2:0];
                REG_SECOND: cfg_reg.second_allele  <= pwdata[2:0];
                REG_THIRD:  cfg_reg.third_allele   <= pwdata[2:0];
                REG_SOLID:  cfg_reg.solid_mode     <= pwdata[0];
                REG_OFFSET: cfg_reg.quality_offset <= pwdata[6:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_FIRST:  prdata = {29'd0, cfg_reg.first_allele};
            REG_SECOND: prdata = {29'd0, cfg_reg.second_allele};
            REG_THIRD:  prdata = {29'd0, cfg_reg.third_allele};
            REG_SOLID:  prdata = {31'd0, cfg_reg.solid_mode};
            REG_OFFSET: prdata = {25'd0, cfg_reg.quality_offset};
            default:    prdata = 32'd0;
        endcase
    end

    glac_front u_front (
        .obs    (obs),
        .cfg    (cfg_reg),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_data)
    );

    glac_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .pop       (q_pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (q_head)
    );

    glac_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .result  (result)
    );
endmodule
`default_nettype wire

### rtl/glac_front.sv
// Front end: accepts items, derives effective quality and update terms, pushes work.
// Depends on glac_pkg.
`default_nettype none
module glac_front
    import glac_pkg::*;
(
    glac_obs_if.sink     obs,
    input  wire cfg_t    cfg,
    input  wire logic    q_full,
    output logic         q_push,
    output entry_t       q_data
);
    logic signed [9:0] q_raw, q_min, q_cap, q_clmp;
    logic [7:0]        q_eff;
    logic              sample_ok, upd_ok, hit;
    logic [1:0]        which;
    logic [ROW_W+1:0]  row_full;
    logic [2:0]        slot_reg;
    logic signed [16:0] cnt;

    assign obs.ready = !q_full;

    always_comb
    begin
        q_raw = $signed({2'b00, obs.base_quality}) - $signed({3'b000, cfg.quality_offset});
        q_min = ($signed({2'b00, obs.mapping_quality}) < q_raw)
              ? $signed({2'b00, obs.mapping_quality}) : q_raw;
        q_cap = (cfg.solid_mode && q_min > $signed({5'b00000, SOLID_CAP}))
              ? $signed({5'b00000, SOLID_CAP}) : q_min;
        if (q_cap < 10'sd1) q_clmp = 10'sd1;
        else if (q_cap > 10'(MAX_QUALITY)) q_clmp = 10'(MAX_QUALITY);
        else q_clmp = q_cap;
        q_eff = q_clmp[7:0];
    end

    always_comb
    begin
        sample_ok = {1'b0, obs.sample} < 7'(NUM_SAMPLES);
        upd_ok    = sample_ok && (obs.strand_class != CLASS_COMBINED);
        row_full  = (ROW_W+2)'({obs.sample, 1'b0}) + (ROW_W+2)'(obs.sample)
                  + (ROW_W+2)'(obs.strand_class);
        slot_reg  = obs.indel_slot ? cfg.third_allele : cfg.second_allele;
        cnt       = $signed({1'b0, obs.indel_count});
        hit   = 1'b1;
        which = 2'd0;
        priority if (obs.base_allele == cfg.first_allele) which = 2'd0;
        else if (obs.base_allele == cfg.second_allele) which = 2'd1;
        else if (obs.base_allele == cfg.third_allele) which = 2'd2;
        else hit = 1'b0;

        q_data          = '0;
        q_data.row      = (sample_ok && obs.strand_class != CLASS_COMBINED)
                        ? row_full[ROW_W-1:0] : '0;
        q_data.combined = obs.strand_class == CLASS_COMBINED;
        q_data.zero     = !sample_ok;
        if (sample_ok && obs.strand_class == CLASS_COMBINED)
            q_data.row = row_full[ROW_W-1:0] - ROW_W'(CLASS_COMBINED);
        q_push = 1'b0;
        unique case (obs.req_type)
            REQ_CLEAR:
            begin
                q_data.op = OP_CLEAR;
                q_push    = 1'b1;
            end
            REQ_BASE:
            begin
                q_data.op    = OP_UPDATE;
                q_data.which = which;
                q_data.m     = (q_eff < 8'(MATCH_SIZE))
                             ? MATCH_TABLE[q_eff[5:0]] : 32'sd0;
                q_data.h     = HALF_TERM;
                q_data.e     = ERR_TABLE[q_eff[QIDX_W-1:0]];
                q_push       = upd_ok && hit;
            end
            REQ_INDEL:
            begin
                q_data.op    = OP_UPDATE;
                q_data.which = obs.indel_slot ? 2'd2 : 2'd1;
                q_data.m     = 32'(cnt * INDEL_MATCH);
                q_data.h     = 32'(cnt * HALF_TERM);
                q_data.e     = 32'(cnt * INDEL_ERROR);
                q_push       = upd_ok && slot_reg[2];
            end
            default:
            begin
                q_data.op = OP_READ;
                q_push    = 1'b1;
            end
        endcase
        q_push = q_push && obs.valid && !q_full;
    end
endmodule
`default_nettype wire

### rtl/glac_fifo.sv
// Two-entry work queue between front end and back end.
// Depends on glac_pkg.
`default_nettype none
module glac_fifo
    import glac_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire entry_t push_data,
    input  wire logic   pop,
    output logic        full,
    output logic        empty,
    output entry_t      head
);
    entry_t     slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;

    assign full  = cnt_reg == 2'd2;
    assign empty = cnt_reg == 2'd0;
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop)  rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) slot_reg[wr_ptr_reg] <= push_data;
    end
endmodule
`default_nettype wire

### rtl/glac_back.sv
// Back end: likelihood store (row memory with per-row valid bits), saturating
// read-modify-write, combined readout and the result register. Depends on glac_pkg.
`default_nettype none
module glac_back
    import glac_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   q_empty,
    input  wire entry_t q_head,
    output logic        q_pop,
    glac_res_if.source  result
);
    typedef enum logic [1:0] { B_IDLE, B_WAIT, B_OUT } bstate_t;

    bstate_t              state_reg;
    entry_t               cur_reg;
    logic [1:0]           cnt_reg;
    logic [ROWS-1:0]      rowv_reg;
    row_t                 mem [ROWS];
    row_t                 rd_data_reg;
    logic                 rd_v_reg;
    logic [ROW_W-1:0]     rd_addr;
    logic                 rd_en;
    logic                 wr_en;
    row_t                 wr_data, cur_row;
    logic signed [33:0]   acc_reg  [NUM_GENO];
    logic signed [33:0]   acc_next [NUM_GENO];
    logic                 out_valid_reg;
    logic [31:0]          out_reg [NUM_GENO];
    logic signed [31:0]   term;

    assign q_pop = (state_reg == B_IDLE) && !q_empty;
    assign cur_row = (rd_v_reg && !cur_reg.zero) ? rd_data_reg : '0;

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = q_head.row;
        if (state_reg == B_IDLE)
            rd_en = !q_empty && q_head.op != OP_CLEAR;
        else if (state_reg == B_WAIT && cur_reg.op == OP_READ && cur_reg.combined
                 && cnt_reg != 2'd2)
        begin
            rd_en   = 1'b1;
            rd_addr = cur_reg.row + ROW_W'(cnt_reg) + ROW_W'(1);
        end
    end

    always_comb
    begin
        for (int j = 0; j < NUM_GENO; j++)
        begin
            unique case (term_sel(cur_reg.which, j))
                TERM_M:  term = cur_reg.m;
                TERM_H:  term = cur_reg.h;
                default: term = cur_reg.e;
            endcase
            wr_data[j] = sat32(34'($signed(cur_row[j])) + 34'(term));
            acc_next[j] = (cnt_reg == 2'd0 ? 34'sd0 : acc_reg[j]) + 34'($signed(cur_row[j]));
        end
        wr_en = (state_reg == B_WAIT) && cur_reg.op == OP_UPDATE;
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (rd_en) rd_data_reg <= mem[rd_addr];
        if (wr_en) mem[cur_reg.row] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            cur_reg       <= '0;
            rowv_reg      <= '0;
            rd_v_reg      <= 1'b0;
            cnt_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
            for (int j = 0; j < NUM_GENO; j++)
            begin
                acc_reg[j] <= '0;
                out_reg[j] <= '0;
            end
        end
        else
        begin
            if (rd_en) rd_v_reg <= rowv_reg[rd_addr];
            // result register: load a new item or drop the one just taken
            priority if (state_reg == B_OUT && (!out_valid_reg || result.ready))
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                B_IDLE:
                begin
                    cnt_reg <= 2'd0;
                    if (!q_empty)
                    begin
                        cur_reg <= q_head;
                        if (q_head.op == OP_CLEAR) rowv_reg <= '0;
                        else state_reg <= B_WAIT;
                    end
                end
                B_WAIT:
                begin
                    if (cur_reg.op == OP_UPDATE)
                    begin
                        rowv_reg[cur_reg.row] <= 1'b1;
                        state_reg <= B_IDLE;
                    end
                    else
                    begin
                        for (int j = 0; j < NUM_GENO; j++) acc_reg[j] <= acc_next[j];
                        cnt_reg <= cnt_reg + 2'd1;
                        if (!cur_reg.combined || cnt_reg == 2'd2) state_reg <= B_OUT;
                    end
                end
                default:
                begin
                    if (!out_valid_reg || result.ready)
                    begin
                        for (int j = 0; j < NUM_GENO; j++) out_reg[j] <= sat32(acc_reg[j]);
                        state_reg <= B_IDLE;
                    end
                end
            endcase
        end
    end

    assign result.valid = out_valid_reg;
    assign result.ll_aa = out_reg[0];
    assign result.ll_ab = out_reg[1];
    assign result.ll_bb = out_reg[2];
    assign result.ll_ac = out_reg[3];
    assign result.ll_bc = out_reg[4];
    assign result.ll_cc = out_reg[5];
endmodule
`default_nettype wire

### rtl/glac_checker.sv
// Port-level checks for the accumulator, attached to the top level by bind.
// Depends on genotype_likelihood_accumulator.
`default_nettype none
module glac_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        res_valid,
    input wire logic        res_ready,
    input wire logic [31:0] res_aa,
    input wire logic        obs_valid,
    input wire logic        obs_ready,
    input wire logic        pready,
    input wire logic [4:0]  paddr,
    input wire logic [31:0] prdata
);
    // result held while stalled
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_aa))
        else $error("result dropped or changed while stalled");

    // no result right out of reset
    a_reset_quiet: assert property (@(posedge clk) $rose(rst_n) |-> !res_valid)
        else $error("result valid right after reset");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

    // the solid mode register is a single bit
    a_solid_width: assert property (@(posedge clk) disable iff (!rst_n)
        paddr[4:2] == 3'd3 |-> prdata[31:1] == 31'd0)
        else $error("solid mode readback too wide");

    // input ready is always a defined level while an item is offered
    a_obs_ready_known: assert property (@(posedge clk) disable iff (!rst_n)
        obs_valid |-> !$isunknown(obs_ready))
        else $error("obs ready unknown");
endmodule

bind genotype_likelihood_accumulator glac_checker u_glac_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res_aa    (result.ll_aa),
    .obs_valid (obs.valid),
    .obs_ready (obs.ready),
    .pready    (pready),
    .paddr     (paddr),
    .prdata    (prdata)
);
`default_nettype wire

### tb/sv/testbench.sv
// Self-checking testbench for genotype_likelihood_accumulator: predicts likelihood
// readouts from accepted items and compares them. Depends on glac_pkg and glac_ifs.
module testbench;
    import glac_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    glac_obs_if obs (.clk(clk));
    glac_res_if result (.clk(clk));

    genotype_likelihood_accumulator u_top (
        .clk(clk), .rst_n(rst_n), .obs(obs), .result(result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    typedef struct packed {
        logic signed [31:0] aa, ab, bb, ac, bc, cc;
    } lik_t;

    // predictor copy of the store and registers
    logic signed [31:0] lik_mem [NUM_SAMPLES][NUM_CLASSES][NUM_GENO];
    logic [2:0] allele_a, allele_b, allele_c;
    logic       solid_on;
    logic [6:0] qual_off;

    lik_t expected_reads[$];
    int   fail_count;
    int   reads_seen;
    int   idle_cycles;
    bit   hold_off;     // long receiver hold-off, set by the pressure test
    int   burst_left;

    localparam logic signed [31:0] MATCH_Q [36] = '{
        0, -2813, -1773, -1237, -903, -676, -515, -396, -307, -239,
        -187, -147, -116, -91, -72, -57, -45, -36, -28, -23,
        -18, -14, -11, -9, -7, -6, -4, -4, -3, -2,
        -2, -1, -1, -1, -1, -1
    };

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic signed [31:0] clip32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7fff_ffff;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // add m/h/e to one class row; w selects which allele matched
    task automatic add_terms(input int s, input int c, input int w,
                             input logic signed [63:0] m, input logic signed [63:0] h,
                             input logic signed [63:0] e);
        logic signed [63:0] d;
        for (int j = 0; j < NUM_GENO; j++)
        begin
            d = e;
            case (w)
                0: if (j == 0) d = m; else if (j == 1 || j == 3) d = h;
                1: if (j == 2) d = m; else if (j == 1 || j == 4) d = h;
                default: if (j == 5) d = m; else if (j == 3 || j == 4) d = h;
            endcase
            lik_mem[s][c][j] = clip32(64'(lik_mem[s][c][j]) + d);
        end
    endtask

    task automatic clear_model();
        for (int s = 0; s < NUM_SAMPLES; s++)
            for (int c = 0; c < NUM_CLASSES; c++)
                for (int j = 0; j < NUM_GENO; j++)
                    lik_mem[s][c][j] = '0;
    endtask

    // work out the effect of one accepted item
    task automatic predict_likelihood(input logic [1:0] rq, input logic [5:0] smp,
                                      input logic [2:0] al, input logic [7:0] bq,
                                      input logic [7:0] mq, input logic [1:0] sc,
                                      input logic slot, input logic [15:0] cnt);
        int q;
        int w;
        logic [2:0] reg_v;
        logic signed [63:0] acc [NUM_GENO];
        lik_t r;
        case (rq)
            REQ_CLEAR: clear_model();
            REQ_BASE:
            begin
                if (sc != CLASS_COMBINED && smp < NUM_SAMPLES)
                begin
                    q = int'(bq) - int'(qual_off);
                    if (int'(mq) < q) q = int'(mq);
                    if (solid_on && q > 30) q = 30;
                    if (q < 1) q = 1;
                    if (q > MAX_QUALITY) q = MAX_QUALITY;
                    w = (al == allele_a) ? 0 : (al == allele_b) ? 1 :
                        (al == allele_c) ? 2 : 3;
                    if (w != 3)
                        add_terms(int'(smp), int'(sc), w,
                                  (q < 36) ? 64'(MATCH_Q[q]) : 64'sd0,
                                  64'(HALF_TERM), -64'((q * 4096 + 5) / 10));
                end
            end
            REQ_INDEL:
            begin
                reg_v = slot ? allele_c : allele_b;
                if (sc != CLASS_COMBINED && smp < NUM_SAMPLES && reg_v >= 4)
                    add_terms(int'(smp), int'(sc), slot ? 2 : 1,
                              $signed(64'(cnt)) * INDEL_MATCH,
                              $signed(64'(cnt)) * HALF_TERM,
                              $signed(64'(cnt)) * INDEL_ERROR);
            end
            default:
            begin
                for (int j = 0; j < NUM_GENO; j++)
                begin
                    acc[j] = 0;
                    if (smp < NUM_SAMPLES)
                    begin
                        if (sc == CLASS_COMBINED)
                            for (int c = 0; c < NUM_CLASSES; c++)
                                acc[j] += 64'(lik_mem[smp][c][j]);
                        else
                            acc[j] = 64'(lik_mem[smp][sc][j]);
                    end
                end
                r.aa = clip32(acc[0]); r.ab = clip32(acc[1]); r.bb = clip32(acc[2]);
                r.ac = clip32(acc[3]); r.bc = clip32(acc[4]); r.cc = clip32(acc[5]);
                expected_reads.push_back(r);
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0d want %0d", what, $signed(got), $signed(want));
        fail_count++;
    endtask

    // APB write: setup then access; pready is always high
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_FIRST:  allele_a = val[2:0];
            REG_SECOND: allele_b = val[2:0];
            REG_THIRD:  allele_c = val[2:0];
            REG_SOLID:  solid_on = val[0];
            default:    qual_off = val[6:0];
        endcase
    endtask

    task automatic set_config(input logic [2:0] a, input logic [2:0] b, input logic [2:0] c,
                              input logic sm, input logic [6:0] off);
        reg_write(REG_FIRST, 32'(a));
        reg_write(REG_SECOND, 32'(b));
        reg_write(REG_THIRD, 32'(c));
        reg_write(REG_SOLID, 32'(sm));
        reg_write(REG_OFFSET, 32'(off));
    endtask

    // Send one item. Bursts: the sender holds valid for a random run of items,
    // then idles for a random gap. valid stays high across back-to-back items.
    task automatic send_item(input logic [1:0] rq, input logic [5:0] smp,
                             input logic [2:0] al, input logic [7:0] bq,
                             input logic [7:0] mq, input logic [1:0] sc,
                             input logic slot, input logic [15:0] cnt);
        if (burst_left == 0)
        begin
            if (obs.valid)
            begin
                obs.valid <= 1'b0;
                @(posedge clk);
            end
            repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 8) : 0) @(posedge clk);
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        obs.valid <= 1'b1;
        obs.req_type <= rq; obs.sample <= smp; obs.base_allele <= al;
        obs.base_quality <= bq; obs.mapping_quality <= mq; obs.strand_class <= sc;
        obs.indel_slot <= slot; obs.indel_count <= cnt;
        do @(posedge clk); while (!obs.ready);
        predict_likelihood(rq, smp, al, bq, mq, sc, slot, cnt);
    endtask

    // drop valid and wait for all reads; a margin covers dropped-result items
    task automatic drain();
        obs.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (expected_reads.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic send_random(input int rq_weight_read);
        logic [1:0] rq;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 1) rq = REQ_CLEAR;
        else if (pick < rq_weight_read) rq = REQ_READ;
        else if (pick < rq_weight_read + 15) rq = REQ_INDEL;
        else rq = REQ_BASE;
        send_item(rq,
                  6'($urandom_range(0, 3) == 0 ? $urandom_range(0, 63) : $urandom_range(0, 3)),
                  3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                  1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
    endtask

    task automatic test_directed_bases();
        set_config(3'd0, 3'd1, 3'd2, 1'b0, 7'd33);
        send_item(REQ_BASE, 6'd0, 3'd0, 8'd255, 8'd255, 2'd0, 1'b0, 16'd0);
        send_item(REQ_BASE, 6'd0, 3'd1, 8'd0, 8'd0, 2'd1, 1'b0, 16'd0);
        send_item(REQ_BASE, 6'd0, 3'd2, 8'd50, 8'd10, 2'd2, 1'b0, 16'd0);
        send_item(REQ_BASE, 6'd0, 3'd7, 8'd60, 8'd60, 2'd0, 1'b0, 16'd0);
        send_item(REQ_BASE, 6'd63, 3'd0, 8'd60, 8'd60, 2'd3, 1'b0, 16'd0);
        for (int c = 0; c < 4; c++)
            send_item(REQ_READ, 6'd0, 3'd0, 8'd0, 8'd0, c[1:0], 1'b0, 16'd0);
        send_item(REQ_READ, 6'd63, 3'd0, 8'd0, 8'd0, 2'd3, 1'b0, 16'd0);
        drain();
        set_config(3'd7, 3'd0, 3'd7, 1'b1, 7'd0);
        send_item(REQ_BASE, 6'd5, 3'd0, 8'd200, 8'd100, 2'd0, 1'b0, 16'd0);
        send_item(REQ_BASE, 6'd5, 3'd7, 8'd200, 8'd100, 2'd0, 1'b0, 16'd0);
        send_item(REQ_READ, 6'd5, 3'd0, 8'd0, 8'd0, 2'd0, 1'b0, 16'd0);
        drain();
    endtask

    // indel terms and saturation: huge counts push sums past the int32 floor
    task automatic test_indel_saturation();
        set_config(3'd0, 3'd4, 3'd6, 1'b0, 7'd64);
        send_item(REQ_CLEAR, 6'd0, 3'd0, 8'd0, 8'd0, 2'd0, 1'b0, 16'd0);
        for (int i = 0; i < 6; i++)
            send_item(REQ_INDEL, 6'd1, 3'd0, 8'd0, 8'd0, 2'(i % 3), 1'(i / 3), 16'hffff);
        send_item(REQ_INDEL, 6'd1, 3'd0, 8'd0, 8'd0, 2'd3, 1'b0, 16'hffff);
        send_item(REQ_READ, 6'd1, 3'd0, 8'd0, 8'd0, 2'd0, 1'b0, 16'd0);
        send_item(REQ_READ, 6'd1, 3'd0, 8'd0, 8'd0, 2'd3, 1'b0, 16'd0);
        drain();
        // slot register below 4: indel ignored
        set_config(3'd0, 3'd1, 3'd2, 1'b0, 7'd33);
        send_item(REQ_INDEL, 6'd2, 3'd0, 8'd0, 8'd0, 2'd0, 1'b1, 16'd100);
        send_item(REQ_READ, 6'd2, 3'd0, 8'd0, 8'd0, 2'd0, 1'b0, 16'd0);
        send_item(REQ_CLEAR, 6'd0, 3'd0, 8'd0, 8'd0, 2'd0, 1'b0, 16'd0);
        send_item(REQ_READ, 6'd1, 3'd0, 8'd0, 8'd0, 2'd3, 1'b0, 16'd0);
        drain();
    endtask

    task automatic test_random_phases();
        for (int p = 0; p < 6; p++)
        begin
            set_config(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                       3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                       7'($urandom_range(0, 64)));
            repeat (120) send_random(25);
            drain();
        end
    endtask

    // receiver holds off a long time while items keep coming
    task automatic test_backpressure();
        set_config(3'd0, 3'd1, 3'd4, 1'b0, 7'd33);
        hold_off = 1'b1;
        repeat (40) send_random(60);
        drain();
    endtask

    // receiver stall pattern; hold-off counted in its own process
    initial
    begin
        result.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                result.ready <= 1'b0;
                repeat (200) @(posedge clk);
                hold_off = 1'b0;
            end
            result.ready <= ($urandom_range(0, 9) < 6) || (reads_seen % 50 < 10);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        lik_t want;
        if (rst_n && result.valid && result.ready)
        begin
            reads_seen++;
            if (expected_reads.size() == 0)
            begin
                $display("unexpected readout item");
                fail_count++;
            end
            else
            begin
                want = expected_reads.pop_front();
                if (result.ll_aa !== want.aa) report_mismatch("ll_aa", result.ll_aa, want.aa);
                if (result.ll_ab !== want.ab) report_mismatch("ll_ab", result.ll_ab, want.ab);
                if (result.ll_bb !== want.bb) report_mismatch("ll_bb", result.ll_bb, want.bb);
                if (result.ll_ac !== want.ac) report_mismatch("ll_ac", result.ll_ac, want.ac);
                if (result.ll_bc !== want.bc) report_mismatch("ll_bc", result.ll_bc, want.bc);
                if (result.ll_cc !== want.cc) report_mismatch("ll_cc", result.ll_cc, want.cc);
            end
        end
    end

    // watchdog on cycles with no accepted item, taken result or APB select
    always @(posedge clk)
    begin
        if ((obs.valid && obs.ready) || (result.valid && result.ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        obs.valid = 1'b0; obs.req_type = REQ_CLEAR; obs.sample = '0; obs.base_allele = '0;
        obs.base_quality = '0; obs.mapping_quality = '0; obs.strand_class = '0;
        obs.indel_slot = 1'b0; obs.indel_count = '0;
        fail_count = 0; reads_seen = 0; idle_cycles = 0; hold_off = 1'b0;
        burst_left = 0;
        allele_a = 3'd0; allele_b = 3'd1; allele_c = 3'd2; solid_on = 1'b0; qual_off = 7'd33;
        clear_model();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_bases();
        test_indel_saturation();
        test_backpressure();
        test_random_phases();
        if (fail_count == 0 && expected_reads.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
